### hw/rtl/swmin_pkg.sv
// Package for the sliding window minimum block.
// Widths and default sizes shared by the cell and the top level; no dependencies.
`default_nettype none

package swmin_pkg;

	localparam int DATA_W = 32;
	localparam int CFG_W = 7;
	localparam int MAX_WINDOW_DEF = 64;
	localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = CFG_W'(1);

endpackage

`default_nettype wire

### hw/rtl/sliding_window_minimum.sv
// Top level of the sliding window minimum block.
// Instantiates a row of swmin_cell; depends on swmin_pkg.
`default_nettype none

// Sliding window minimum: accepts one signed 32-bit sample per clock while the output
// is not stalled and, once at least window_size samples of the current sequence are
// held, returns the minimum of the last window_size samples in the cycle after the
// sample's transfer. A sample with start_new set begins a new sequence; no result is
// given until the window fills. A row of MAX_WINDOW cells keeps, in cell k, the
// minimum over the last k+1 samples; each cell takes one compare against its
// neighbour per sample, so the block sustains one sample per cycle, limited only by
// output stalls. window_size 0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW.
// Write it only while idle.
module sliding_window_minimum #(
	parameter int MAX_WINDOW = swmin_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wen,
	input  wire logic [swmin_pkg::CFG_W-1:0]           cfg_wdata,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [swmin_pkg::DATA_W-1:0]   sample,
	input  wire logic                                  start_new,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [swmin_pkg::DATA_W-1:0]        window_min
);

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W = (CNT_W > swmin_pkg::CFG_W) ? CNT_W : swmin_pkg::CFG_W;

	logic [swmin_pkg::CFG_W-1:0] window_size_q;
	logic [CNT_W-1:0]            fill_q;
	logic [CNT_W-1:0]            fill_nxt;
	logic [CMP_W-1:0]            ws_ext;
	logic [CMP_W-1:0]            w_eff;
	logic                        in_xfer;
	logic                        emit;
	logic [swmin_pkg::DATA_W-1:0] min_sel;

	logic signed [swmin_pkg::DATA_W-1:0] cell_m [MAX_WINDOW];
	logic        [swmin_pkg::DATA_W-1:0] cell_tap [MAX_WINDOW];

	assign in_stall = out_valid && out_stall;
	assign in_xfer  = in_valid && !in_stall;

	assign ws_ext = CMP_W'(window_size_q);
	always_comb begin
		if (ws_ext == '0) begin
			w_eff = CMP_W'(1);
		end else if (ws_ext > CMP_W'(MAX_WINDOW)) begin
			w_eff = CMP_W'(MAX_WINDOW);
		end else begin
			w_eff = ws_ext;
		end
	end

	always_comb begin
		if (start_new) begin
			fill_nxt = CNT_W'(1);
		end else if (fill_q < CNT_W'(MAX_WINDOW)) begin
			fill_nxt = fill_q + CNT_W'(1);
		end else begin
			fill_nxt = fill_q;
		end
	end

	assign emit = CMP_W'(fill_nxt) >= w_eff;

	for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
		swmin_cell u_cell (
			.clk  (clk),
			.en   (in_xfer),
			.sel  (w_eff == CMP_W'(k + 1)),
			.x    (sample),
			.prev ((k == 0) ? sample : cell_m[(k == 0) ? 0 : k - 1]),
			.m_q  (cell_m[k]),
			.tap  (cell_tap[k])
		);
	end

	always_comb begin
		min_sel = '0;
		for (int k = 0; k < MAX_WINDOW; k++) begin
			min_sel = min_sel | cell_tap[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= swmin_pkg::WINDOW_SIZE_RST;
			fill_q        <= '0;
			out_valid     <= 1'b0;
		end else begin
			if (cfg_wen) begin
				window_size_q <= cfg_wdata;
			end
			if (in_xfer) begin
				fill_q    <= fill_nxt;
				out_valid <= emit;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			window_min <= $signed(min_sel);
		end
	end

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_WINDOW))
		else $error("fill count beyond window depth");

	a_fresh_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && start_new && w_eff != CMP_W'(1) |=> !out_valid)
		else $error("result given for first sample of a sequence");

	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && w_eff == CMP_W'(1) |=> out_valid && window_min == $past(sample))
		else $error("window of one does not pass the sample through");

	a_accept_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output register");
`endif

endmodule

`default_nettype wire

### hw/rtl/swmin_cell.sv
// One cell of the running-minimum chain.
// Holds the minimum over the samples of ages 0..k; depends on swmin_pkg.
`default_nettype none

module swmin_cell (
	input  wire logic                                  clk,
	input  wire logic                                  en,
	input  wire logic                                  sel,
	input  wire logic signed [swmin_pkg::DATA_W-1:0]   x,
	input  wire logic signed [swmin_pkg::DATA_W-1:0]   prev,
	output logic signed [swmin_pkg::DATA_W-1:0]        m_q,
	output logic        [swmin_pkg::DATA_W-1:0]        tap
);

	logic signed [swmin_pkg::DATA_W-1:0] nxt;

	// new min over ages 0..k = min(new sample, old min over ages 0..k-1)
	assign nxt = (x < prev) ? x : prev;
	assign tap = sel ? nxt : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			m_q <= nxt;
		end
	end

endmodule

`default_nettype wire

### tb/swmin_checker.sv
// Checker for the sliding window minimum block: watches the configuration port and both
// channels, predicts the window minimum of every sample transfer once the window has
// filled and compares the results. Depends on swmin_pkg.
`timescale 1ns / 1ps

module swmin_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wen,
	input  logic [swmin_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic signed [swmin_pkg::DATA_W-1:0]   sample,
	input  logic                                  start_new,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic signed [swmin_pkg::DATA_W-1:0]   window_min,
	output int                                    errors,
	output int                                    outstanding
);

	localparam int DEPTH = swmin_pkg::MAX_WINDOW_DEF;

	logic signed [swmin_pkg::DATA_W-1:0] history [DEPTH];
	logic signed [swmin_pkg::DATA_W-1:0] expected_min [$];
	logic [swmin_pkg::CFG_W-1:0]         window_reg;
	int                                  held;
	int                                  wr_ptr;

	// size 0 acts as 1, anything above the store depth as the depth
	function automatic int span(input logic [swmin_pkg::CFG_W-1:0] r);
		if (r == 0)
			return 1;
		if (r > DEPTH)
			return DEPTH;
		return int'(r);
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $time, what);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic signed [swmin_pkg::DATA_W-1:0] lo;
		logic signed [swmin_pkg::DATA_W-1:0] want;
		int                                  w;
		if (!arst_n) begin
			window_reg = swmin_pkg::WINDOW_SIZE_RST;
			held = 0;
			wr_ptr = 0;
			errors = 0;
			expected_min.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_min.size() == 0) begin
					report_mismatch($sformatf("result %0d with none outstanding", window_min));
				end else begin
					want = expected_min.pop_front();
					if (window_min !== want)
						report_mismatch($sformatf("window_min %0d, expected %0d",
							window_min, want));
				end
			end
			if (in_valid && !in_stall) begin
				if (start_new)
					held = 0;
				history[wr_ptr] = sample;
				wr_ptr = (wr_ptr + 1) % DEPTH;
				if (held < DEPTH)
					held++;
				w = span(window_reg);
				if (held >= w) begin
					lo = sample;
					for (int i = 1; i < w; i++) begin
						if (history[(wr_ptr + DEPTH - 1 - i) % DEPTH] < lo)
							lo = history[(wr_ptr + DEPTH - 1 - i) % DEPTH];
					end
					expected_min.push_back(lo);
				end
			end
			if (cfg_wen)
				window_reg = cfg_wdata;
		end
		outstanding <= expected_min.size();
	end

endmodule

### tb/tb_sliding_window_minimum.sv
// Testbench top for sliding_window_minimum: clock, reset, window size writes, sample
// stimulus and receiver stalls; swmin_checker does the prediction and comparison.
// Depends on swmin_pkg, sliding_window_minimum and swmin_checker.
`timescale 1ns / 1ps

module tb_sliding_window_minimum;

	localparam int DATA_W = swmin_pkg::DATA_W;
	localparam int CFG_W = swmin_pkg::CFG_W;
	localparam int DEPTH = swmin_pkg::MAX_WINDOW_DEF;
	localparam logic signed [DATA_W-1:0] LOWEST = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] HIGHEST = {1'b0, {(DATA_W-1){1'b1}}};
	localparam int QUIET_LIMIT = 5000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wen = 1'b0;
	logic [CFG_W-1:0]         cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic signed [DATA_W-1:0] sample = '0;
	logic                     start_new = 1'b0;
	logic                     out_stall = 1'b0;
	logic                     in_stall;
	logic                     out_valid;
	logic signed [DATA_W-1:0] window_min;
	int                       errors;
	int                       outstanding;
	int                       send_idle_pct = 0;
	int                       recv_stall_pct = 0;
	int                       quiet = 0;

	sliding_window_minimum dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.start_new  (start_new),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.window_min (window_min)
	);

	swmin_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.start_new   (start_new),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.window_min  (window_min),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// no transfer for too long: hung
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("sliding_window_minimum verification failed");
				$finish;
			end
		end
	end

	function automatic logic signed [DATA_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return LOWEST;
			1:       return HIGHEST;
			2, 3:    return $signed($urandom_range(0, 16)) - 8;
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic push_sample(input logic signed [DATA_W-1:0] value, input logic fresh);
		bit taken;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= value;
		start_new <= fresh;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window(input logic [CFG_W-1:0] value);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// sequences mostly at least one window long; some cut short, a few restarted midway
	task automatic run_phase(input logic [CFG_W-1:0] size, input int count);
		int  w;
		int  left;
		int  len;
		bit  first;
		write_window(size);
		w = (size == 0) ? 1 : ((size > DEPTH) ? DEPTH : int'(size));
		left = count;
		first = 1'b1;
		while (left > 0) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(1, w);
			else
				len = w + $urandom_range(0, 2 * w + 4);
			if (len > left)
				len = left;
			for (int i = 0; i < len; i++) begin
				if (i == 0)
					push_sample(pick_sample(), first ? 1'($urandom_range(0, 1)) : 1'b1);
				else
					push_sample(pick_sample(), $urandom_range(0, 49) == 0);
			end
			left -= len;
			first = 1'b0;
		end
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 13;
		recv_stall_pct = 82;

		// window size at its reset value: pass-through
		push_sample(LOWEST, 1'b1);
		push_sample(HIGHEST, 1'b0);
		push_sample(0, 1'b0);
		drain();

		write_window(3);
		push_sample(10, 1'b1);
		push_sample(HIGHEST, 1'b0);
		push_sample(LOWEST, 1'b0);
		push_sample(-1, 1'b0);
		push_sample(1, 1'b0);
		// old minimum leaves the window
		push_sample(7, 1'b0);
		push_sample(7, 1'b0);
		push_sample(HIGHEST, 1'b0);
		push_sample(HIGHEST, 1'b0);
		push_sample(HIGHEST, 1'b0);
		// sequence shorter than the window
		push_sample(3, 1'b1);
		push_sample(2, 1'b0);
		// equal values
		push_sample(9, 1'b1);
		push_sample(9, 1'b0);
		push_sample(9, 1'b0);
		drain();

		run_phase(1, 100);
		run_phase(0, 80);
		run_phase(2, 100);
		run_phase(7'h7f, 130);

		send_idle_pct = 82;
		recv_stall_pct = 13;
		run_phase(CFG_W'(DEPTH), 200);
		run_phase(5, 100);
		run_phase(CFG_W'(DEPTH + 1), 120);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_phase(7, 100);
		run_phase(CFG_W'($urandom_range(1, DEPTH)), 100);
		run_phase(3, 70);

		if (errors == 0)
			$display("sliding_window_minimum verification clean");
		else
			$display("sliding_window_minimum verification failed");
		$finish;
	end

endmodule
